@@ src/kdb_pkg.sv @@
// ----------------------------------------------------------------------------
// kdb_pkg: shared types and constants for the key debounce core
// Event codes, register indexes, reset values and the transaction structs.
// ----------------------------------------------------------------------------
package kdb_pkg;

  // Event codes carried in the event slot and on the result channel
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_PRESSED  = 3'd1,
    EV_CLICKED  = 3'd2,
    EV_RELEASED = 3'd3,
    EV_LONG     = 3'd4
  } event_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LOW = 2'd2;

  // Register reset values
  localparam logic [15:0] DebounceRst  = 16'd20;
  localparam logic [15:0] LongPressRst = 16'd1000;
  localparam logic        ActiveLowRst = 1'b1;

  localparam int unsigned TimeW = 32;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic        active_low;
  } cfg_t;

  typedef struct packed {
    logic             mode;
    logic             pin_high;
    logic [TimeW-1:0] now_ms;
    logic             take_event;
  } item_t;

  typedef struct packed {
    event_e event_res;
    logic   stable_pressed;
  } res_t;

endpackage

@@ src/kdb_if.sv @@
// ----------------------------------------------------------------------------
// kdb_in_if / kdb_out_if: valid/ready channels of the key debounce core
// Scan transactions in, one result transaction out per scan.
// ----------------------------------------------------------------------------
interface kdb_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic                     pin_high;
  logic [kdb_pkg::TimeW-1:0] now_ms;
  logic                     take_event;

  modport source (output valid, mode, pin_high, now_ms, take_event, input ready);
  modport sink   (input valid, mode, pin_high, now_ms, take_event, output ready);
endinterface

interface kdb_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic       stable_pressed;

  modport source (output valid, event_res, stable_pressed, input ready);
  modport sink   (input valid, event_res, stable_pressed, output ready);
endinterface

@@ src/kdb_step.sv @@
// ----------------------------------------------------------------------------
// kdb_step: debounce state and per-scan update
// Holds the key state and computes the result of one registered scan.
// ----------------------------------------------------------------------------
module kdb_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  kdb_pkg::item_t item_i,
  input  kdb_pkg::cfg_t  cfg_i,
  output kdb_pkg::res_t  res_o
);
  import kdb_pkg::*;

  logic             stable_q, stable_d;
  logic             last_raw_q, last_raw_d;
  logic             long_q, long_d;
  logic [TimeW-1:0] rct_q, rct_d;
  logic [TimeW-1:0] press_q, press_d;
  event_e           pend_q, pend_d;

  logic             raw;
  logic             raw_chg;
  logic [TimeW-1:0] deb_age;
  logic             deb_ok;
  logic             press_now;
  logic [TimeW-1:0] press_age;
  logic             long_hit;
  event_e           ev;

  // Next state and result of one scan
  always_comb begin
    raw     = item_i.pin_high ^ cfg_i.active_low;
    raw_chg = raw != last_raw_q;
    // a raw change restarts the timer, so its age is zero this scan
    deb_age = raw_chg ? '0 : item_i.now_ms - rct_q;
    deb_ok  = (raw != stable_q) && (deb_age >= {16'b0, cfg_i.debounce_ms});
    press_now = deb_ok && raw;
    press_age = press_now ? '0 : item_i.now_ms - press_q;

    stable_d   = deb_ok ? raw : stable_q;
    last_raw_d = raw;
    rct_d      = raw_chg ? item_i.now_ms : rct_q;
    press_d    = press_now ? item_i.now_ms : press_q;
    long_d     = press_now ? 1'b0 : long_q;
    ev         = pend_q;

    if (deb_ok) begin
      if (raw) begin
        ev = EV_PRESSED;
      end else begin
        ev = long_q ? EV_RELEASED : EV_CLICKED;
      end
    end

    long_hit = stable_d && !long_d && (press_age >= {16'b0, cfg_i.long_press_ms});
    if (long_hit) begin
      long_d = 1'b1;
      ev     = EV_LONG;
    end

    // init transaction loads the level and clears everything else
    if (item_i.mode) begin
      stable_d   = raw;
      last_raw_d = raw;
      long_d     = 1'b0;
      rct_d      = '0;
      press_d    = '0;
      ev         = EV_NONE;
    end

    // consume returns the slot and empties it
    if (item_i.take_event) begin
      res_o.event_res = ev;
      pend_d          = EV_NONE;
    end else begin
      res_o.event_res = EV_NONE;
      pend_d          = ev;
    end
    res_o.stable_pressed = stable_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= 1'b0;
      last_raw_q <= 1'b0;
      long_q     <= 1'b0;
      rct_q      <= '0;
      press_q    <= '0;
      pend_q     <= EV_NONE;
    end else if (en_i) begin
      stable_q   <= stable_d;
      last_raw_q <= last_raw_d;
      long_q     <= long_d;
      rct_q      <= rct_d;
      press_q    <= press_d;
      pend_q     <= pend_d;
    end
  end

endmodule

@@ src/key_debounce_click_long_press_core.sv @@
// ----------------------------------------------------------------------------
// key_debounce_click_long_press_core: debounced key with click/long press
// Debounces one key from timestamped scans and reports its events.
// ----------------------------------------------------------------------------
// Every scan transaction yields exactly one result transaction. A scan is
// captured in an input register, evaluated there against the key state and
// placed in an output register once that register can take it; one scan can
// be accepted every cycle while results drain, and the output register is
// the only point of back-pressure. Each scan updates the state through two
// 32-bit modulo-2^32 age compares (debounce age and press age). Registers
// (debounce_ms, long_press_ms, active_low) are to be written through cfg_we_i
// only while no transaction is in flight; the core does not enforce this.
module key_debounce_click_long_press_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kdb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [kdb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  kdb_in_if.sink                        in_ch,
  kdb_out_if.source                     out_ch
);
  import kdb_pkg::*;

  cfg_t  cfg_q;
  logic  in_valid_q;
  item_t item_q;
  logic  out_valid_q;
  res_t  res_q;
  res_t  res_step;
  logic  step_en;
  logic  in_fire;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DebounceRst;
      cfg_q.long_press_ms <= LongPressRst;
      cfg_q.active_low    <= ActiveLowRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_wdata_i;
        CFG_LONG_PRESS: cfg_q.long_press_ms <= cfg_wdata_i;
        CFG_ACTIVE_LOW: cfg_q.active_low    <= cfg_wdata_i[0];
        default:        ;
      endcase
    end
  end

  // Handshake: scan stage moves when the output register can take it
  assign step_en      = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready  = !in_valid_q || step_en;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.mode       <= in_ch.mode;
      item_q.pin_high   <= in_ch.pin_high;
      item_q.now_ms     <= in_ch.now_ms;
      item_q.take_event <= in_ch.take_event;
    end
  end

  // Scan evaluation and key state
  kdb_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step_en),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res_step)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= res_step;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.event_res      = res_q.event_res;
  assign out_ch.stable_pressed = res_q.stable_pressed;

  // A scan without consume never reports an event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && !item_q.take_event) |=> (out_ch.event_res == EV_NONE))
    else $error("event reported without consume");

  // An init transaction posts nothing and loads the mapped pin level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && item_q.mode) |=>
      (out_ch.event_res == EV_NONE) &&
      (out_ch.stable_pressed == ($past(item_q.pin_high) ^ $past(cfg_q.active_low))))
    else $error("init transaction result wrong");

  // A held scan stays in the input register until it is evaluated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step_en) |=> in_valid_q && $stable(item_q))
    else $error("stalled scan lost");

  // Output register only fills from an evaluated scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_en))
    else $error("result without scan");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for key_debounce_click_long_press_core
// Drives timestamped scan transactions with bursty valid and a stalling
// result sink, predicts every result in a scoreboard class and compares
// each result transaction field by field. Several register settings are
// run, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
  import kdb_pkg::*;

  localparam int unsigned StallLimit = 3000;  // cycles with no transaction
  localparam int unsigned LongHold   = 400;   // receiver hold-off under pressure
  localparam int unsigned DrainWait  = 6;     // settle cycles after last result

  // Scoreboard: tracks the key state and queues the result due for each scan
  class kdb_event_tracker;
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic        active_low;
    logic        stable_lvl;
    logic        last_raw;
    logic        long_seen;
    logic [31:0] raw_change_at;
    logic [31:0] press_at;
    event_e      slot;
    res_t        due_results[$];
    int unsigned mismatches;

    function new();
      debounce_ms   = DebounceRst;
      long_press_ms = LongPressRst;
      active_low    = ActiveLowRst;
      stable_lvl    = 1'b0;
      last_raw      = 1'b0;
      long_seen     = 1'b0;
      raw_change_at = '0;
      press_at      = '0;
      slot          = EV_NONE;
      mismatches    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_DEBOUNCE:   debounce_ms   = data;
        CFG_LONG_PRESS: long_press_ms = data;
        CFG_ACTIVE_LOW: active_low    = data[0];
        default: ;
      endcase
    endfunction

    // Accepted scan: advance the key state and queue the expected result
    function void note_scan(item_t it);
      logic        raw;
      logic [31:0] age;
      res_t        r;
      raw = active_low ? ~it.pin_high : it.pin_high;
      r.event_res = EV_NONE;
      if (it.mode) begin
        stable_lvl    = raw;
        last_raw      = raw;
        long_seen     = 1'b0;
        raw_change_at = '0;
        press_at      = '0;
        slot          = EV_NONE;
      end else begin
        // any raw change restarts the debounce timer
        if (raw != last_raw) begin
          last_raw      = raw;
          raw_change_at = it.now_ms;
        end
        age = it.now_ms - raw_change_at;
        if (raw != stable_lvl && age >= {16'd0, debounce_ms}) begin
          stable_lvl = raw;
          if (raw) begin
            press_at  = it.now_ms;
            long_seen = 1'b0;
            slot      = EV_PRESSED;
          end else begin
            slot = long_seen ? EV_RELEASED : EV_CLICKED;
          end
        end
        age = it.now_ms - press_at;
        if (stable_lvl && !long_seen && age >= {16'd0, long_press_ms}) begin
          long_seen = 1'b1;
          slot      = EV_LONG;
        end
      end
      if (it.take_event) begin
        r.event_res = slot;
        slot        = EV_NONE;
      end
      r.stable_pressed = stable_lvl;
      due_results.push_back(r);
    endfunction

    // Accepted result: compare with the oldest expectation
    function void check_result(logic [2:0] ev, logic pressed);
      res_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with none expected: event_res=%0d stable_pressed=%0b",
                 $time, ev, pressed);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (want.event_res !== ev) begin
        $display("%0t: event_res mismatch: expected %0d, actual %0d",
                 $time, want.event_res, ev);
        mismatches++;
      end
      if (want.stable_pressed !== pressed) begin
        $display("%0t: stable_pressed mismatch: expected %0b, actual %0b",
                 $time, want.stable_pressed, pressed);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  kdb_in_if  in_ch ();
  kdb_out_if out_ch ();

  key_debounce_click_long_press_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  kdb_event_tracker tracker = new();

  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  logic [31:0] clk_ms     = '0;
  bit          hold_req   = 1'b0;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Pin level that gives the wanted pressed level under the current polarity
  function automatic logic pin_for(logic pressed);
    return tracker.active_low ? ~pressed : pressed;
  endfunction

  function automatic int unsigned near(int unsigned x);
    int unsigned d;
    d = $urandom_range(0, 4);
    return (x + d < 2) ? 0 : x + d - 2;
  endfunction

  // Offer one scan transaction; the sender works in bursts with gaps between
  task automatic send_scan(logic mode, logic pin, logic [31:0] stamp, logic take);
    item_t       it;
    int unsigned gap;
    it.mode       = mode;
    it.pin_high   = pin;
    it.now_ms     = stamp;
    it.take_event = take;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= it.mode;
    in_ch.pin_high   <= it.pin_high;
    in_ch.now_ms     <= it.now_ms;
    in_ch.take_event <= it.take_event;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    tracker.note_scan(it);
    items_sent++;
  endtask

  task automatic scan(logic lvl, logic [31:0] stamp, logic take);
    clk_ms = stamp;
    send_scan(1'b0, pin_for(lvl), stamp, take);
  endtask

  task automatic init_key(logic lvl, logic [31:0] stamp, logic take);
    clk_ms = stamp;
    send_scan(1'b1, pin_for(lvl), stamp, take);
  endtask

  // Wait until every expected result has arrived and the core has settled
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Write all three registers while the core is idle
  task automatic load_key_setup(logic [15:0] deb, logic [15:0] lng, logic al);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DEBOUNCE;
    cfg_wdata_i <= deb;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_LONG_PRESS;
    cfg_wdata_i <= lng;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_ACTIVE_LOW;
    cfg_wdata_i <= {15'd0, al};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_reg(CFG_DEBOUNCE, deb);
    tracker.set_reg(CFG_LONG_PRESS, lng);
    tracker.set_reg(CFG_ACTIVE_LOW, {15'd0, al});
  endtask

  // Hold one pressed level for a number of scans spread over span ms
  task automatic hold_level(logic lvl, int unsigned span, int unsigned scans);
    logic [31:0] first;
    first = clk_ms + $urandom_range(1, 3);
    scan(lvl, first, $urandom_range(0, 9) < 4);
    for (int unsigned i = 1; i < scans; i++) begin
      scan(lvl, first + (span * i) / (scans - 1), $urandom_range(0, 9) < 4);
    end
  endtask

  // One key gesture: press bounce, hold, release bounce, rest
  task automatic gesture();
    int unsigned deb;
    int unsigned lng;
    int unsigned span;
    deb = {16'd0, tracker.debounce_ms};
    lng = {16'd0, tracker.long_press_ms};
    for (int unsigned b = $urandom_range(0, 3); b > 0; b--) begin
      hold_level(b[0], $urandom_range(0, (deb > 0) ? deb - 1 : 0), $urandom_range(1, 2));
    end
    case ($urandom_range(0, 2))
      0:       span = near(deb);
      1:       span = near(deb + lng);
      default: span = $urandom_range(0, 2 * (deb + lng) + 20);
    endcase
    hold_level(1'b1, span, $urandom_range(2, 5));
    for (int unsigned b = $urandom_range(0, 3); b > 0; b--) begin
      hold_level(~b[0], $urandom_range(0, (deb > 0) ? deb - 1 : 0), $urandom_range(1, 2));
    end
    span = $urandom_range(0, 1) ? near(deb) : $urandom_range(deb, 3 * deb + 20);
    hold_level(1'b0, span, $urandom_range(2, 4));
  endtask

  // Mostly well-formed gestures, with noise, init transactions and time jumps
  task automatic random_scans(int unsigned quota);
    int unsigned target;
    target = items_sent + quota;
    clk_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        7: begin
          repeat ($urandom_range(1, 6)) begin
            clk_ms = $urandom_range(0, 7) ? clk_ms + $urandom_range(0, 40) : $urandom;
            send_scan(1'b0, 1'($urandom_range(0, 1)), clk_ms, 1'($urandom_range(0, 1)));
          end
        end
        8: send_scan(1'b1, 1'($urandom_range(0, 1)), clk_ms, 1'($urandom_range(0, 1)));
        9: begin
          clk_ms = clk_ms + $urandom;
          send_scan(1'b0, 1'($urandom_range(0, 1)), clk_ms, 1'($urandom_range(0, 1)));
        end
        default: gesture();
      endcase
    end
  endtask

  // Result sink: checks each result transaction and stalls on its own pattern
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned phase_left;
    int unsigned stall_mode;
    hold_left  = 0;
    phase_left = 0;
    stall_mode = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_result(out_ch.event_res, out_ch.stable_pressed);
      end
      if (hold_left == 0 && hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 120);
        end
        phase_left--;
        case (stall_mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (phase_left % 5 != 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transaction for %0d cycles", $time, StallLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_DEBOUNCE;
    cfg_wdata_i      <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= 1'b0;
    in_ch.pin_high   <= 1'b0;
    in_ch.now_ms     <= '0;
    in_ch.take_event <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: init, debounce edges, long press, release, wrap-around
    scan(1'b0, 32'd0, 1'b1);
    init_key(1'b1, 32'd5, 1'b1);           // init pressed, consume gives none
    scan(1'b1, 32'd1004, 1'b1);            // long press counted from time zero after init
    init_key(1'b0, 32'hFFFF_FFFF, 1'b0);
    scan(1'b1, 32'd100, 1'b0);
    scan(1'b0, 32'd105, 1'b0);             // bounce
    scan(1'b1, 32'd110, 1'b0);
    scan(1'b1, 32'd129, 1'b1);             // one ms short of debounce
    scan(1'b1, 32'd130, 1'b1);             // pressed
    scan(1'b1, 32'd1129, 1'b1);
    scan(1'b1, 32'd1130, 1'b0);            // long press, left in the slot
    scan(1'b0, 32'd1135, 1'b0);
    scan(1'b0, 32'd1154, 1'b1);
    scan(1'b0, 32'd1155, 1'b1);            // released after long press
    scan(1'b1, 32'd2000, 1'b0);
    scan(1'b1, 32'd2020, 1'b0);
    scan(1'b0, 32'd2100, 1'b0);
    scan(1'b0, 32'd2120, 1'b1);            // click overwrites pressed
    scan(1'b1, 32'hFFFF_FFF0, 1'b0);
    scan(1'b1, 32'h0000_0010, 1'b1);       // debounce across the wrap
    scan(1'b0, 32'h0000_0020, 1'b0);
    scan(1'b0, 32'h0000_0040, 1'b0);
    init_key(1'b0, 32'h0000_0041, 1'b1);   // init clears a pending click
    random_scans(150);

    // Zero times, active-high pin: long press overwrites pressed
    load_key_setup(16'd0, 16'd0, 1'b0);
    scan(1'b1, 32'd50, 1'b1);
    scan(1'b1, 32'd51, 1'b1);
    scan(1'b0, 32'd52, 1'b1);
    scan(1'b0, 32'd53, 1'b0);
    random_scans(150);

    // Largest times, with a long receiver hold-off to fill the core
    load_key_setup(16'hFFFF, 16'hFFFF, 1'b1);
    hold_req = 1'b1;
    random_scans(200);

    load_key_setup(16'd3, 16'd10, 1'b0);
    random_scans(150);

    load_key_setup(16'd1, 16'd0, 1'b1);
    random_scans(150);

    load_key_setup(16'd0, 16'hFFFF, 1'b0);
    random_scans(100);

    load_key_setup(16'($urandom_range(0, 50)), 16'($urandom_range(0, 300)),
                   1'($urandom_range(0, 1)));
    random_scans(150);

    drain_results();
    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
